>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks that compile away when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising edge, masked while reset is active.
`define SSRC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define SSRC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SSRC_ASSERT(name, clk, rst_n, prop, msg)
`define SSRC_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

>>> rtl/ssrc_pkg.sv
// ---------------------------------------------------------------------------
// ssrc_pkg
// Widths, constants, codes and types shared by the servo ramp controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssrc_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DDEG_W  = 11;
  localparam int unsigned PULSE_W = 12;
  localparam int unsigned INTV_W  = 16;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 4;

  localparam logic [DDEG_W-1:0]  FULL_DDEG   = 11'd1800;
  localparam logic [DDEG_W-1:0]  CENTER_DDEG = 11'd900;
  localparam logic [ANGLE_W-1:0] MAX_DEG     = 8'd180;

  // Fixed-point reciprocals, 16 fraction bits, rounded up; exact over 0..1800.
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned PULSE_RW    = 17;
  localparam int unsigned DEG_RW      = 13;
  localparam logic [PULSE_RW-1:0] PULSE_RECIP = 17'd72818;  // 2000/1800
  localparam logic [DEG_RW-1:0]   DEG_RECIP   = 13'd6554;   // 1/10

  // Register reset values
  localparam logic [DDEG_W-1:0] MIN_PULSE_RST = 11'd500;
  localparam logic [INTV_W-1:0] INTERVAL_RST  = 16'd20;
  localparam logic [DDEG_W-1:0] STEP_SIZE_RST = 11'd10;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_SET  = 2'd1,
    FUNC_MOVE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    REG_MIN_PULSE     = 2'd0,
    REG_STEP_INTERVAL = 2'd1,
    REG_STEP_SIZE     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [DDEG_W-1:0] min_pulse_us;
    logic [INTV_W-1:0] step_interval_ms;
    logic [DDEG_W-1:0] step_size_ddeg;
  } cfg_t;

  // Clamp to 180 degrees, then scale to tenths.
  function automatic logic [DDEG_W-1:0] angle_to_ddeg(input logic [ANGLE_W-1:0] a);
    logic [DDEG_W-1:0] d;
    d = {{(DDEG_W-ANGLE_W){1'b0}}, ((a > MAX_DEG) ? MAX_DEG : a)};
    return (d << 3) + (d << 1);
  endfunction

endpackage

`default_nettype wire

>>> rtl/ssrc_stream_if.sv
// ---------------------------------------------------------------------------
// ssrc stream interfaces
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssrc_in_if import ssrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [ANGLE_W-1:0] angle_deg;
  logic [TIME_W-1:0]  now_ms;

  modport source (output valid, func, angle_deg, now_ms, input ready);
  modport sink   (input valid, func, angle_deg, now_ms, output ready);
endinterface

interface ssrc_out_if import ssrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] pulse_us;
  logic [DDEG_W-1:0]  position_ddeg;
  logic [ANGLE_W-1:0] position_deg;
  logic               done_res;

  modport source (output valid, pulse_us, position_ddeg, position_deg, done_res,
                  input ready);
  modport sink   (input valid, pulse_us, position_ddeg, position_deg, done_res,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/ssrc_regs.sv
// ---------------------------------------------------------------------------
// ssrc_regs
// APB configuration registers: min pulse, step interval, step size.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssrc_regs import ssrc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MIN_PULSE:     cfg_d.min_pulse_us     = pwdata[DDEG_W-1:0];
        REG_STEP_INTERVAL: cfg_d.step_interval_ms = pwdata[INTV_W-1:0];
        REG_STEP_SIZE:     cfg_d.step_size_ddeg   = pwdata[DDEG_W-1:0];
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_PULSE:     prdata = {{(APB_DW-DDEG_W){1'b0}}, cfg_q.min_pulse_us};
      REG_STEP_INTERVAL: prdata = {{(APB_DW-INTV_W){1'b0}}, cfg_q.step_interval_ms};
      REG_STEP_SIZE:     prdata = {{(APB_DW-DDEG_W){1'b0}}, cfg_q.step_size_ddeg};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse_us     <= MIN_PULSE_RST;
      cfg_q.step_interval_ms <= INTERVAL_RST;
      cfg_q.step_size_ddeg   <= STEP_SIZE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/servo_slew_ramp_controller.sv
// ---------------------------------------------------------------------------
// servo_slew_ramp_controller
// Servo position keeper with slew-limited ramp and PWM compare output.
// ---------------------------------------------------------------------------
// Usage:
//  - in_i carries command items: func (tick / direct set / ramped move),
//    angle_deg and the millisecond timestamp now_ms.
//  - out_o returns exactly one result item per command: pulse compare value,
//    position in tenths and whole degrees, and the done flag.
//  - APB port writes min_pulse_us (0x0), step_interval_ms (0x4) and
//    step_size_ddeg (0x8); write only while no item is in flight.
// Timing:
//  - Three registered stages: input register, state update (position,
//    target, last step time, moving), output scaling (two constant
//    multiplies). An accepted item passes through them in that order.
//  - Throughput is 1 item per cycle unless out_o stalls; the state loop sets it.
// Reset: position and target return to 900 (90 deg), no move armed, step
//   timestamp zero, registers to 500 us / 20 ms / 10 ddeg. Pipeline empties.
// Stall: when out_o.ready is low the finished item stays on out_o; items
//   keep being taken until every stage holds one, then in_i.ready drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module servo_slew_ramp_controller import ssrc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  ssrc_in_if.sink                in_i,
  ssrc_out_if.source             out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned PULSE_PW = DDEG_W + PULSE_RW;
  localparam int unsigned DEG_PW   = DDEG_W + DEG_RW;

  cfg_t cfg;

  ssrc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---- stage advance: a stage moves when its successor is free or moving
  logic out_move, mid_move, in_move;

  logic               in_v_q;
  logic [FUNC_W-1:0]  in_func_q;
  logic [ANGLE_W-1:0] in_angle_q;
  logic [TIME_W-1:0]  in_now_q;

  logic               mid_v_q;
  logic [DDEG_W-1:0]  mid_pos_q;
  logic               mid_done_q;

  logic               out_v_q;
  logic [PULSE_W-1:0] out_pulse_q;
  logic [DDEG_W-1:0]  out_pos_q;
  logic [ANGLE_W-1:0] out_deg_q;
  logic               out_done_q;

  assign out_move  = !out_v_q || out_o.ready;
  assign mid_move  = !mid_v_q || out_move;
  assign in_move   = !in_v_q || mid_move;
  assign in_i.ready = in_move;

  // ---- input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_move) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_move && in_i.valid) begin
      in_func_q  <= in_i.func;
      in_angle_q <= in_i.angle_deg;
      in_now_q   <= in_i.now_ms;
    end
  end

  // ---- servo state
  logic [DDEG_W-1:0] position_q, position_d;
  logic [DDEG_W-1:0] target_q, target_d;
  logic [TIME_W-1:0] last_q, last_d;
  logic              moving_q, moving_d;
  logic              step_en;

  assign step_en = in_v_q && mid_move;

  logic [DDEG_W-1:0] ang_ddeg;
  logic [TIME_W-1:0] elapsed;
  logic              due;
  logic [DDEG_W:0]   up_sum;
  logic [DDEG_W-1:0] up_pos, dn_diff, dn_pos, tick_pos;
  func_e             func;

  assign func     = func_e'(in_func_q);
  assign ang_ddeg = angle_to_ddeg(in_angle_q);
  assign elapsed  = in_now_q - last_q;  // wraps with the ms counter
  assign due      = moving_q &&
                    (elapsed >= {{(TIME_W-INTV_W){1'b0}}, cfg.step_interval_ms});

  // Up: never pass the target. Down: land on zero when the step underflows.
  assign up_sum  = {1'b0, position_q} + {1'b0, cfg.step_size_ddeg};
  assign up_pos  = (up_sum > {1'b0, target_q}) ? target_q : up_sum[DDEG_W-1:0];
  assign dn_diff = position_q - cfg.step_size_ddeg;
  assign dn_pos  = (position_q < cfg.step_size_ddeg) ? '0 :
                   ((dn_diff < target_q) ? target_q : dn_diff);

  always_comb begin
    priority if (position_q < target_q) begin
      tick_pos = up_pos;
    end else if (position_q > target_q) begin
      tick_pos = dn_pos;
    end else begin
      tick_pos = position_q;
    end
  end

  always_comb begin
    position_d = position_q;
    target_d   = target_q;
    last_d     = last_q;
    moving_d   = moving_q;
    unique case (func)
      FUNC_TICK: begin
        if (due) begin
          last_d     = in_now_q;
          position_d = tick_pos;
          moving_d   = (tick_pos != target_q);
        end
      end
      FUNC_SET: begin
        position_d = ang_ddeg;  // armed move keeps going from here
      end
      FUNC_MOVE: begin
        if (ang_ddeg != position_q) begin
          target_d = ang_ddeg;
          moving_d = 1'b1;
          last_d   = in_now_q;
        end
      end
      default: ;  // unused code: report state only
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= CENTER_DDEG;
      target_q   <= CENTER_DDEG;
      last_q     <= '0;
      moving_q   <= 1'b0;
    end else if (step_en) begin
      position_q <= position_d;
      target_q   <= target_d;
      last_q     <= last_d;
      moving_q   <= moving_d;
    end
  end

  // ---- middle stage: snapshot of the updated state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_v_q <= 1'b0;
    end else if (mid_move) begin
      mid_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      mid_pos_q  <= position_d;
      mid_done_q <= !moving_d;
    end
  end

  // ---- output stage: pulse = min + pos*2000/1800, deg = pos/10
  logic [PULSE_PW-1:0] pulse_prod;
  logic [DEG_PW-1:0]   deg_prod;
  logic [PULSE_W-1:0]  pulse_val;

  assign pulse_prod = PULSE_PW'(mid_pos_q) * PULSE_PW'(PULSE_RECIP);
  assign deg_prod   = DEG_PW'(mid_pos_q) * DEG_PW'(DEG_RECIP);
  assign pulse_val  = PULSE_W'(cfg.min_pulse_us) +
                      pulse_prod[RECIP_SHIFT +: PULSE_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_move) begin
      out_v_q <= mid_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_move && mid_v_q) begin
      out_pulse_q <= pulse_val;
      out_pos_q   <= mid_pos_q;
      out_deg_q   <= deg_prod[RECIP_SHIFT +: ANGLE_W];
      out_done_q  <= mid_done_q;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.pulse_us      = out_pulse_q;
  assign out_o.position_ddeg = out_pos_q;
  assign out_o.position_deg  = out_deg_q;
  assign out_o.done_res      = out_done_q;

  // ---- checks
  `SSRC_ASSERT(a_pos_range, clk_i, rst_ni, (position_q <= FULL_DDEG), "position above 1800")
  `SSRC_ASSERT(a_move_ends_on_target, clk_i, rst_ni, ($fell(moving_q) |-> (position_q == target_q)), "move ended off target")
  `SSRC_ASSERT(a_mid_hold, clk_i, rst_ni, ((mid_v_q && !out_move) |=> (mid_v_q && $stable(mid_pos_q) && $stable(mid_done_q))), "middle stage lost while stalled")
  `SSRC_ASSERT(a_accept_loads, clk_i, rst_ni, ((in_i.valid && in_move) |=> in_v_q), "accepted item not registered")

endmodule

`default_nettype wire

>>> tb/servo_slew_ramp_controller_tb.sv
// ---------------------------------------------------------------------------
// servo_slew_ramp_controller_tb
// Self-checking bench for the servo slew ramp controller. A short directed
// table covers reset state, angle clamping, ignored moves, direct set during
// a move, timestamp wrap, zero step size, downward underflow and register
// extremes. Three random phases follow, each under its own register set and
// idle/stall mix. Every accepted item is scored against its typed result or
// the in-bench ramp predictor; the register port is read back after every write.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_slew_ramp_controller_tb;
  import ssrc_pkg::*;

  localparam int unsigned PIPE_LATENCY    = 3;
  localparam int unsigned ITEMS_PER_PHASE = 276;
  localparam int unsigned PULSE_SPAN_US   = 2000;
  localparam int unsigned DDEG_PER_DEG    = 10;

  // func code 3 has no enum member; the block must treat it as a no-op
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_us;
    logic [DDEG_W-1:0]  position_ddeg;
    logic [ANGLE_W-1:0] position_deg;
    logic               done_res;
  } servo_result_t;

  // One row of the directed table: either a register write or a command item,
  // the latter optionally carrying a hand-written expected result.
  typedef struct packed {
    bit                 is_cfg;
    reg_idx_e           reg_idx;
    logic [APB_DW-1:0]  reg_value;
    logic [FUNC_W-1:0]  func;
    logic [ANGLE_W-1:0] angle_deg;
    logic [TIME_W-1:0]  now_ms;
    bit                 typed;
    servo_result_t      expected;
  } stim_row_t;

  logic clk;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ssrc_in_if  in_if ();
  ssrc_out_if out_if ();

  servo_slew_ramp_controller DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: registers as last written, plus the ramp state
  cfg_t               servo_cfg;
  logic [DDEG_W-1:0]  pos_ddeg;
  logic [DDEG_W-1:0]  goal_ddeg;
  logic [TIME_W-1:0]  last_step_ms;
  logic               ramp_armed;

  servo_result_t pending_results[$];
  int unsigned   fail_count;
  int unsigned   src_idle_pct;
  int unsigned   sink_stall_pct;
  logic [TIME_W-1:0] session_ms;

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Result side backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic logic [DDEG_W-1:0] deg_to_ddeg(logic [ANGLE_W-1:0] a);
    int unsigned deg;
    deg = (a > MAX_DEG) ? MAX_DEG : a;
    return DDEG_W'(deg * DDEG_PER_DEG);
  endfunction

  // Applies one command item to the predictor state and returns the result
  // item the block must produce for it.
  task automatic ramp_predict(input logic [FUNC_W-1:0] f, input logic [ANGLE_W-1:0] a,
                              input logic [TIME_W-1:0] now, output servo_result_t r);
    logic [TIME_W-1:0] elapsed;
    logic [DDEG_W-1:0] req;
    int unsigned       nxt;
    int unsigned       p;
    case (f)
      FUNC_TICK: begin
        elapsed = now - last_step_ms;
        if (ramp_armed && elapsed >= TIME_W'(servo_cfg.step_interval_ms)) begin
          last_step_ms = now;
          if (pos_ddeg < goal_ddeg) begin
            nxt = pos_ddeg + servo_cfg.step_size_ddeg;
            if (nxt > goal_ddeg) nxt = goal_ddeg;
            if (nxt > FULL_DDEG) nxt = FULL_DDEG;
            pos_ddeg = DDEG_W'(nxt);
          end else if (pos_ddeg > goal_ddeg) begin
            // a step that would go below zero lands on zero, past the goal
            if (pos_ddeg < servo_cfg.step_size_ddeg) begin
              pos_ddeg = '0;
            end else begin
              nxt = pos_ddeg - servo_cfg.step_size_ddeg;
              if (nxt < goal_ddeg) nxt = goal_ddeg;
              pos_ddeg = DDEG_W'(nxt);
            end
          end
          if (pos_ddeg == goal_ddeg) ramp_armed = 1'b0;
        end
      end
      FUNC_SET: begin
        pos_ddeg = deg_to_ddeg(a);
      end
      FUNC_MOVE: begin
        // a move onto the current position changes nothing at all
        req = deg_to_ddeg(a);
        if (req != pos_ddeg) begin
          goal_ddeg    = req;
          ramp_armed   = 1'b1;
          last_step_ms = now;
        end
      end
      default: ;
    endcase
    p = pos_ddeg;
    r.pulse_us      = PULSE_W'(servo_cfg.min_pulse_us + (p * PULSE_SPAN_US) / FULL_DDEG);
    r.position_ddeg = DDEG_W'(p);
    r.position_deg  = ANGLE_W'(p / DDEG_PER_DEG);
    r.done_res      = !ramp_armed;
  endtask

  // Drives one command item from a falling edge, holds it until taken, then
  // queues its expected result. Returns at the next falling edge with valid
  // still high so back-to-back items need no extra assignment.
  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [ANGLE_W-1:0] a,
                          input logic [TIME_W-1:0] t, input bit typed,
                          input servo_result_t typed_res);
    servo_result_t r;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= f;
    in_if.angle_deg <= a;
    in_if.now_ms    <= t;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    ramp_predict(f, a, t, r);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  // Stop sending and let every outstanding result arrive
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  // Register write followed by a read-back, back to back; starts and ends at
  // a falling edge.
  task automatic apb_write(input reg_idx_e idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] stored;
    case (idx)
      REG_MIN_PULSE: begin
        stored = value & 32'h7FF;
        servo_cfg.min_pulse_us = DDEG_W'(value);
      end
      REG_STEP_INTERVAL: begin
        stored = value & 32'hFFFF;
        servo_cfg.step_interval_ms = INTV_W'(value);
      end
      default: begin
        stored = value & 32'h7FF;
        servo_cfg.step_size_ddeg = DDEG_W'(value);
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    // straight into the setup phase of the read-back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    check_field("prdata", stored, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic stim_row_t cmd_row(logic [FUNC_W-1:0] f, logic [ANGLE_W-1:0] a,
                                        logic [TIME_W-1:0] t, bit typed = 1'b0,
                                        servo_result_t r = '0);
    stim_row_t row;
    row           = '0;
    row.func      = f;
    row.angle_deg = a;
    row.now_ms    = t;
    row.typed     = typed;
    row.expected  = r;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(reg_idx_e idx, logic [APB_DW-1:0] value);
    stim_row_t row;
    row           = '0;
    row.is_cfg    = 1'b1;
    row.reg_idx   = idx;
    row.reg_value = value;
    return row;
  endfunction

  // Score every result item against the oldest expectation
  always @(posedge clk) begin
    servo_result_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with no expectation pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("pulse_us", want.pulse_us, out_if.pulse_us);
        check_field("position_ddeg", want.position_ddeg, out_if.position_ddeg);
        check_field("position_deg", want.position_deg, out_if.position_deg);
        check_field("done_res", want.done_res, out_if.done_res);
      end
    end
  end

  initial begin
    stim_row_t          directed_rows[$];
    logic [FUNC_W-1:0]  f;
    logic [ANGLE_W-1:0] a;
    logic [TIME_W-1:0]  t;
    int unsigned        roll;

    // Everything the block sees is known from time zero
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.func      = '0;
    in_if.angle_deg = '0;
    in_if.now_ms    = '0;
    out_if.ready    = 1'b0;
    fail_count      = 0;
    src_idle_pct    = 22;
    sink_stall_pct  = 76;
    session_ms      = '0;

    servo_cfg.min_pulse_us     = MIN_PULSE_RST;
    servo_cfg.step_interval_ms = INTERVAL_RST;
    servo_cfg.step_size_ddeg   = STEP_SIZE_RST;
    pos_ddeg     = CENTER_DDEG;
    goal_ddeg    = CENTER_DDEG;
    last_step_ms = '0;
    ramp_armed   = 1'b0;

    // Directed table. Typed results: reset state, clamp extremes, an ignored
    // move, arming a move, and the register extremes on the pulse value.
    directed_rows.push_back(cmd_row(FUNC_TICK, 8'd0, 32'd0, 1'b1,
                                    '{12'd1500, 11'd900, 8'd90, 1'b1}));
    directed_rows.push_back(cmd_row(FUNC_SET, 8'd0, 32'd0, 1'b1,
                                    '{12'd500, 11'd0, 8'd0, 1'b1}));
    // angle above 180 clamps
    directed_rows.push_back(cmd_row(FUNC_SET, 8'd255, 32'hFFFF_FFFF, 1'b1,
                                    '{12'd2500, 11'd1800, 8'd180, 1'b1}));
    // move onto the current position is dropped
    directed_rows.push_back(cmd_row(FUNC_MOVE, 8'd180, 32'd50, 1'b1,
                                    '{12'd2500, 11'd1800, 8'd180, 1'b1}));
    directed_rows.push_back(cmd_row(FUNC_MOVE, 8'd0, 32'd100, 1'b1,
                                    '{12'd2500, 11'd1800, 8'd180, 1'b0}));
    directed_rows.push_back(cmd_row(FUNC_TICK, 8'd0, 32'd119));   // one ms short
    directed_rows.push_back(cmd_row(FUNC_TICK, 8'd0, 32'd120));   // first step
    directed_rows.push_back(cmd_row(FUNC_SET, 8'd90, 32'd0));     // jump mid-move
    directed_rows.push_back(cmd_row(FUNC_TICK, 8'd0, 32'd140));
    directed_rows.push_back(cmd_row(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF));
    // move armed just before the timestamp wraps
    directed_rows.push_back(cmd_row(FUNC_MOVE, 8'd200, 32'hFFFF_FFF0));
    directed_rows.push_back(cmd_row(FUNC_TICK, 8'd0, 32'h0000_0003));
    directed_rows.push_back(cmd_row(FUNC_TICK, 8'd0, 32'h0000_0004));
    // zero step: armed but stuck
    directed_rows.push_back(cfg_row(REG_STEP_SIZE, 32'd0));
    directed_rows.push_back(cmd_row(FUNC_TICK, 8'h55, 32'h0000_0100));
    // downward underflow lands on zero past the goal, then ramps back up
    directed_rows.push_back(cfg_row(REG_STEP_SIZE, 32'd25));
    directed_rows.push_back(cfg_row(REG_STEP_INTERVAL, 32'd0));
    directed_rows.push_back(cmd_row(FUNC_SET, 8'd2, 32'd0));
    directed_rows.push_back(cmd_row(FUNC_MOVE, 8'd1, 32'd0));
    directed_rows.push_back(cmd_row(FUNC_TICK, 8'd0, 32'd0));
    directed_rows.push_back(cmd_row(FUNC_TICK, 8'd0, 32'd0));
    // widest pulse: largest min pulse at full travel, one oversized step
    directed_rows.push_back(cfg_row(REG_MIN_PULSE, 32'hFFFF_FFFF));
    directed_rows.push_back(cfg_row(REG_STEP_SIZE, 32'hFFFF_FFFF));
    directed_rows.push_back(cmd_row(FUNC_MOVE, 8'd180, 32'd7));
    directed_rows.push_back(cmd_row(FUNC_TICK, 8'd0, 32'd7, 1'b1,
                                    '{12'd4047, 11'd1800, 8'd180, 1'b1}));
    // longest interval, zero min pulse
    directed_rows.push_back(cfg_row(REG_MIN_PULSE, 32'd0));
    directed_rows.push_back(cfg_row(REG_STEP_INTERVAL, 32'hFFFF_FFFF));
    directed_rows.push_back(cmd_row(FUNC_SET, 8'd0, 32'd0, 1'b1,
                                    '{12'd0, 11'd0, 8'd0, 1'b1}));
    directed_rows.push_back(cmd_row(FUNC_MOVE, 8'd128, 32'd5));
    directed_rows.push_back(cmd_row(FUNC_TICK, 8'd0, 32'd65539));
    directed_rows.push_back(cmd_row(FUNC_TICK, 8'd0, 32'd65540));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_idle();
        apb_write(directed_rows[i].reg_idx, directed_rows[i].reg_value);
      end else begin
        send_cmd(directed_rows[i].func, directed_rows[i].angle_deg, directed_rows[i].now_ms,
                 directed_rows[i].typed, directed_rows[i].expected);
      end
    end

    // Random phases. Most items are ramp sessions: a move, then ticks whose
    // timestamps advance around the step interval, with sets mixed in; a
    // small share is noise with any func code and any timestamp.
    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          src_idle_pct   = 22;
          sink_stall_pct = 76;
          apb_write(REG_MIN_PULSE, 32'd2000);
          apb_write(REG_STEP_INTERVAL, 32'd65535);
          apb_write(REG_STEP_SIZE, 32'd1800);
        end
        1: begin
          src_idle_pct   = 76;
          sink_stall_pct = 22;
          apb_write(REG_MIN_PULSE, 32'd0);
          apb_write(REG_STEP_INTERVAL, 32'd0);
          apb_write(REG_STEP_SIZE, 32'd1);
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          apb_write(REG_MIN_PULSE, $urandom_range(0, 2047));
          apb_write(REG_STEP_INTERVAL, $urandom_range(1, 100));
          apb_write(REG_STEP_SIZE, $urandom_range(1, 200));
        end
      endcase
      // session clock starts anywhere, so some phases cross the wrap
      session_ms = $urandom;
      repeat (ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        a = ($urandom_range(0, 9) == 0) ? ANGLE_W'($urandom_range(181, 255))
                                        : ANGLE_W'($urandom_range(0, 180));
        if (roll < 6) begin
          f = FUNC_W'($urandom_range(0, 3));
          a = ANGLE_W'($urandom);
          t = $urandom;
        end else if (roll < 18) begin
          f = FUNC_MOVE;
          t = session_ms;
        end else if (roll < 26) begin
          f = FUNC_SET;
          t = $urandom;
        end else begin
          session_ms += $urandom_range(0, 2 * 32'(servo_cfg.step_interval_ms) + 1);
          f = FUNC_TICK;
          a = ANGLE_W'($urandom);
          t = session_ms;
        end
        send_cmd(f, a, t, 1'b0, '0);
      end
    end

    in_if.valid <= 1'b0;
    for (int i = 0; i < 5000 && pending_results.size() != 0; i++) @(posedge clk);
    repeat (PIPE_LATENCY + 5) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result items never arrived", pending_results.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
